>>> src/sgs_pkg.sv
// Shared constants, coefficient tables and lookup functions for the
// Savitzky-Golay smoother. No dependencies; used by every module in src.
package sgs_pkg;

    localparam int MAX_TAPS     = 25;
    localparam int MAX_HALF     = (MAX_TAPS - 1) / 2;
    localparam int NUM_ROWS     = 9;
    localparam int SAMPLE_BITS  = 16;
    localparam int COUNT_BITS   = 16;
    localparam int CFG_BITS     = 5;
    localparam int ADDR_BITS    = $clog2(MAX_TAPS);
    localparam int IDX_BITS     = ADDR_BITS + 1;
    localparam int HALF_BITS    = $clog2(MAX_HALF + 1);
    localparam int ROW_BITS     = $clog2(NUM_ROWS);
    localparam int WEIGHT_BITS  = 11;
    localparam int PROD_BITS    = WEIGHT_BITS + SAMPLE_BITS + 2;
    localparam int ACC_BITS     = 32;
    localparam int NORM_BITS    = 13;
    localparam int DIV_BITS     = ACC_BITS + 2;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS + 1);
    localparam int OUT_BITS     = 18;

    localparam logic [CFG_BITS-1:0] RESET_TAPS = CFG_BITS'(9);
    localparam logic [CFG_BITS-1:0] MIN_TAPS   = CFG_BITS'(9);

    localparam logic signed [OUT_BITS-1:0] SAT_HI = {1'b0, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [OUT_BITS-1:0] SAT_LO = {1'b1, {(OUT_BITS-1){1'b0}}};

    // Weights from the center tap outward, one row per window 9, 11, ..., 25.
    localparam int SG_WEIGHT [NUM_ROWS][MAX_HALF+1] = '{
        '{ 59,  54,  39,  14, -21,   0,   0,   0,   0,   0,   0,    0,    0},
        '{ 89,  84,  69,  44,   9, -36,   0,   0,   0,   0,   0,    0,    0},
        '{ 25,  24,  21,  16,   9,   0, -11,   0,   0,   0,   0,    0,    0},
        '{167, 162, 147, 122,  87,  42, -13, -78,   0,   0,   0,    0,    0},
        '{ 43,  42,  39,  34,  27,  18,   7,  -6, -21,   0,   0,    0,    0},
        '{269, 264, 249, 224, 189, 144,  89,  24, -51,-136,   0,    0,    0},
        '{329, 324, 309, 284, 249, 204, 149,  84,   9, -76,-171,    0,    0},
        '{ 79,  78,  75,  70,  63,  54,  43,  30,  15,  -2, -21,  -42,    0},
        '{467, 462, 447, 422, 387, 342, 287, 222, 147,  62, -33, -138, -253}
    };

    localparam int SG_NORM [NUM_ROWS] = '{231, 429, 143, 1105, 323, 2261, 3059, 805, 5175};

    function automatic logic signed [WEIGHT_BITS-1:0] weight(
        input logic [ROW_BITS-1:0]  row,
        input logic [HALF_BITS-1:0] k,
        input logic                 ok
    );
        if (!ok) begin
            return '0;
        end
        return WEIGHT_BITS'(SG_WEIGHT[row][k]);
    endfunction

    function automatic logic [NORM_BITS-1:0] norm(input logic [ROW_BITS-1:0] row);
        return NORM_BITS'(SG_NORM[row]);
    endfunction

endpackage

>>> src/sgs_store.sv
// Circular sample store for the smoother: one write port, two registered
// read ports. Depends on sgs_pkg for depth and widths.
module sgs_store (
    input  logic                               i_clk,
    input  logic                               i_wr_en,
    input  logic [sgs_pkg::ADDR_BITS-1:0]      i_wr_addr,
    input  logic [sgs_pkg::SAMPLE_BITS-1:0]    i_wr_data,
    input  logic [sgs_pkg::ADDR_BITS-1:0]      i_rd_addr_a,
    input  logic [sgs_pkg::ADDR_BITS-1:0]      i_rd_addr_b,
    output logic [sgs_pkg::SAMPLE_BITS-1:0]    o_rd_data_a,
    output logic [sgs_pkg::SAMPLE_BITS-1:0]    o_rd_data_b
);

    logic [sgs_pkg::SAMPLE_BITS-1:0] r_mem [sgs_pkg::MAX_TAPS];
    logic [sgs_pkg::SAMPLE_BITS-1:0] r_rd_a;
    logic [sgs_pkg::SAMPLE_BITS-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_rd_addr_a];
        r_rd_b <= r_mem[i_rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> src/sgs_div.sv
// Bit-serial restoring divider that rounds |sum| / norm to nearest and
// saturates the signed result. Depends on sgs_pkg.
module sgs_div (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic signed [sgs_pkg::ACC_BITS-1:0]   i_acc,
    input  logic [sgs_pkg::NORM_BITS-1:0]         i_norm,
    output logic                                  o_done,
    output logic signed [sgs_pkg::OUT_BITS-1:0]   o_result
);

    logic                                r_busy;
    logic                                r_done;
    logic [sgs_pkg::DIV_CNT_BITS-1:0]    r_cnt;
    logic [sgs_pkg::DIV_BITS-1:0]        r_q;
    logic [sgs_pkg::NORM_BITS:0]         r_rem;
    logic [sgs_pkg::NORM_BITS:0]         r_dvs;
    logic                                r_neg;

    logic [sgs_pkg::ACC_BITS-1:0]        mag;
    logic [sgs_pkg::DIV_BITS-1:0]        dividend;
    logic [sgs_pkg::NORM_BITS+1:0]       rem_sh;
    logic                                q_bit;
    logic                                big;

    assign mag      = i_acc[sgs_pkg::ACC_BITS-1] ? sgs_pkg::ACC_BITS'(-i_acc)
                                                 : sgs_pkg::ACC_BITS'(i_acc);
    // Rounding to nearest: floor((2a + N) / 2N).
    assign dividend = {1'b0, mag, 1'b0} + sgs_pkg::DIV_BITS'(i_norm);
    assign rem_sh   = {r_rem, r_q[sgs_pkg::DIV_BITS-1]};
    assign q_bit    = rem_sh >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= sgs_pkg::DIV_CNT_BITS'(sgs_pkg::DIV_BITS);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == sgs_pkg::DIV_CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= dividend;
            r_rem <= '0;
            r_dvs <= {i_norm, 1'b0};
            r_neg <= i_acc[sgs_pkg::ACC_BITS-1];
        end else if (r_busy) begin
            r_q   <= {r_q[sgs_pkg::DIV_BITS-2:0], q_bit};
            r_rem <= q_bit ? (sgs_pkg::NORM_BITS+1)'(rem_sh - {1'b0, r_dvs})
                           : (sgs_pkg::NORM_BITS+1)'(rem_sh);
        end
    end

    assign big = |r_q[sgs_pkg::DIV_BITS-1:sgs_pkg::OUT_BITS];

    always_comb begin
        if (!r_neg) begin
            o_result = (big || r_q[sgs_pkg::OUT_BITS-1]) ? sgs_pkg::SAT_HI
                     : sgs_pkg::OUT_BITS'(r_q[sgs_pkg::OUT_BITS-1:0]);
        end else begin
            o_result = (big || (r_q[sgs_pkg::OUT_BITS-1] && (|r_q[sgs_pkg::OUT_BITS-2:0])))
                     ? sgs_pkg::SAT_LO
                     : sgs_pkg::OUT_BITS'(-r_q[sgs_pkg::OUT_BITS-1:0]);
        end
    end

    assign o_done = r_done;

endmodule

>>> src/savitzky_golay_smoother.sv
// Top level of the quadratic Savitzky-Golay smoother: sequencer, tap
// multiply-accumulate and output register. Depends on sgs_pkg, sgs_store, sgs_div.
//
// Each accepted sample is written into a 25-entry circular store; once a full
// window of the frame has arrived, each result walks the window taps one pair
// per cycle through a single multiplier (offsets 0 to half, half = (taps-1)/2),
// drains a three-stage multiply-accumulate pipe, then rounds and saturates
// through a bit-serial divider with a 34-bit quotient register. The frame-end
// sample flushes its remaining results back to back. A new request is taken
// only when the previous one has been fully worked off; the last result may
// still wait in the output register while the next request enters.
module savitzky_golay_smoother (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic [sgs_pkg::SAMPLE_BITS-1:0]       i_sample,
    input  logic                                  i_frame_end,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [sgs_pkg::OUT_BITS-1:0]   o_smoothed,
    output logic                                  o_last_of_frame,
    output logic                                  o_too_short,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [sgs_pkg::CFG_BITS-1:0]          i_cfg_window_taps
);

    typedef enum logic [2:0] {S_IDLE, S_TAP, S_DRAIN, S_DIV, S_EMIT} t_state;

    t_state                                r_state;
    logic [sgs_pkg::CFG_BITS-1:0]          r_window_taps;
    logic [sgs_pkg::ADDR_BITS-1:0]         r_ptr;
    logic [sgs_pkg::COUNT_BITS-1:0]        r_seen;
    logic [sgs_pkg::COUNT_BITS-1:0]        r_given;
    logic [sgs_pkg::ADDR_BITS-1:0]         r_d;
    logic [sgs_pkg::ADDR_BITS-1:0]         r_dend;
    logic [sgs_pkg::HALF_BITS-1:0]         r_k;
    logic [sgs_pkg::HALF_BITS-1:0]         r_half;
    logic [sgs_pkg::ROW_BITS-1:0]          r_row;
    logic                                  r_row_ok;
    logic                                  r_fend;
    logic                                  r_short;
    logic [1:0]                            r_drain;
    logic                                  r_out_valid;
    logic signed [sgs_pkg::OUT_BITS-1:0]   r_out_smoothed;
    logic                                  r_out_last;
    logic                                  r_out_short;

    logic                                  r_p1_valid;
    logic                                  r_p1_va;
    logic                                  r_p1_vb;
    logic [sgs_pkg::HALF_BITS-1:0]         r_p1_k;
    logic                                  r_p2_valid;
    logic signed [sgs_pkg::PROD_BITS-1:0]  r_prod;
    logic signed [sgs_pkg::ACC_BITS-1:0]   r_acc;

    logic                                  in_acc;
    logic                                  out_free;
    logic                                  win_ok;
    logic [sgs_pkg::CFG_BITS-1:0]          win_len;
    logic [sgs_pkg::HALF_BITS-1:0]         win_half;
    logic [sgs_pkg::ROW_BITS-1:0]          win_row;
    logic [sgs_pkg::COUNT_BITS-1:0]        n_seen;
    logic [sgs_pkg::COUNT_BITS-1:0]        n_given;
    logic [sgs_pkg::ADDR_BITS-1:0]         wr_ptr;
    logic [sgs_pkg::IDX_BITS-1:0]          d_ext;
    logic [sgs_pkg::IDX_BITS-1:0]          k_ext;
    logic [sgs_pkg::IDX_BITS-1:0]          plus;
    logic [sgs_pkg::IDX_BITS-1:0]          minus;
    logic [sgs_pkg::IDX_BITS-1:0]          a_idx;
    logic [sgs_pkg::IDX_BITS-1:0]          b_idx;
    logic                                  a_ok;
    logic                                  b_ok;
    logic                                  k_gt_i;
    logic                                  k_gt_d;
    logic [sgs_pkg::SAMPLE_BITS-1:0]       rd_a;
    logic [sgs_pkg::SAMPLE_BITS-1:0]       rd_b;
    logic [sgs_pkg::SAMPLE_BITS:0]         tap_sum;
    logic signed [sgs_pkg::WEIGHT_BITS-1:0] wgt;
    logic                                  div_start;
    logic                                  div_done;
    logic signed [sgs_pkg::OUT_BITS-1:0]   div_result;

    // Logical index 0 is the newest sample, held at the write pointer.
    function automatic logic [sgs_pkg::ADDR_BITS-1:0] phys(
        input logic [sgs_pkg::IDX_BITS-1:0]  idx,
        input logic [sgs_pkg::ADDR_BITS-1:0] ptr
    );
        logic [sgs_pkg::IDX_BITS-1:0] p;
        p = {1'b0, ptr};
        if (p >= idx) begin
            return sgs_pkg::ADDR_BITS'(p - idx);
        end
        return sgs_pkg::ADDR_BITS'(p + sgs_pkg::IDX_BITS'(sgs_pkg::MAX_TAPS) - idx);
    endfunction

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    assign win_ok   = r_window_taps[0] && (r_window_taps >= sgs_pkg::MIN_TAPS)
                      && (r_window_taps <= sgs_pkg::CFG_BITS'(sgs_pkg::MAX_TAPS));
    assign win_len  = win_ok ? r_window_taps : sgs_pkg::CFG_BITS'(1);
    assign win_half = sgs_pkg::HALF_BITS'((win_len - 1'b1) >> 1);
    assign win_row  = win_ok ? sgs_pkg::ROW_BITS'((r_window_taps - sgs_pkg::MIN_TAPS) >> 1)
                             : '0;

    assign n_seen  = (r_seen == '1) ? r_seen : r_seen + 1'b1;
    assign n_given = (r_given == '1) ? r_given : r_given + 1'b1;
    assign wr_ptr  = (r_ptr == sgs_pkg::ADDR_BITS'(sgs_pkg::MAX_TAPS - 1)) ? '0
                                                                           : r_ptr + 1'b1;

    // Tap pair addressing; a tap past the frame start or end mirrors about d.
    assign d_ext  = {1'b0, r_d};
    assign k_ext  = sgs_pkg::IDX_BITS'(r_k);
    assign plus   = d_ext + k_ext;
    assign minus  = d_ext - k_ext;
    assign k_gt_i = sgs_pkg::COUNT_BITS'(r_k) > r_given;
    assign k_gt_d = k_ext > d_ext;

    always_comb begin
        if (r_k == '0) begin
            a_idx = d_ext;
            a_ok  = 1'b1;
            b_idx = d_ext;
            b_ok  = 1'b0;
        end else begin
            if (k_gt_i) begin
                a_idx = minus;
                a_ok  = !k_gt_d;
            end else begin
                a_idx = plus;
                a_ok  = plus < sgs_pkg::IDX_BITS'(sgs_pkg::MAX_TAPS);
            end
            if (k_gt_d) begin
                b_idx = plus;
                b_ok  = plus < sgs_pkg::IDX_BITS'(sgs_pkg::MAX_TAPS);
            end else begin
                b_idx = minus;
                b_ok  = 1'b1;
            end
        end
    end

    sgs_store u_store (
        .i_clk       (i_clk),
        .i_wr_en     (in_acc),
        .i_wr_addr   (wr_ptr),
        .i_wr_data   (i_sample),
        .i_rd_addr_a (phys(a_idx, r_ptr)),
        .i_rd_addr_b (phys(b_idx, r_ptr)),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign tap_sum = (r_p1_va ? {1'b0, rd_a} : '0) + (r_p1_vb ? {1'b0, rd_b} : '0);
    assign wgt     = sgs_pkg::weight(r_row, r_p1_k, r_row_ok);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_valid <= 1'b0;
            r_p2_valid <= 1'b0;
        end else begin
            r_p1_valid <= (r_state == S_TAP);
            r_p2_valid <= r_p1_valid;
        end
        r_p1_va <= a_ok;
        r_p1_vb <= b_ok;
        r_p1_k  <= r_k;
        r_prod  <= sgs_pkg::PROD_BITS'(wgt)
                   * sgs_pkg::PROD_BITS'($signed({1'b0, tap_sum}));
        if (r_state == S_IDLE || r_state == S_EMIT) begin
            r_acc <= '0;
        end else if (r_p2_valid) begin
            r_acc <= r_acc + sgs_pkg::ACC_BITS'(r_prod);
        end
    end

    assign div_start = (r_state == S_DRAIN) && (r_drain == 2'd0);

    sgs_div u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (div_start),
        .i_acc    (r_acc),
        .i_norm   (sgs_pkg::norm(r_row)),
        .o_done   (div_done),
        .o_result (div_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_window_taps <= sgs_pkg::RESET_TAPS;
            r_ptr         <= '0;
            r_seen        <= '0;
            r_given       <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_window_taps <= i_cfg_window_taps;
            end
            // In the emit state the output register is refilled below instead.
            if (r_out_valid && i_out_ready && (r_state != S_EMIT)) begin
                r_out_valid <= 1'b0;
            end
            if (in_acc) begin
                r_ptr <= wr_ptr;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (n_seen < sgs_pkg::COUNT_BITS'(win_len)) begin
                            if (i_frame_end) begin
                                // Frame ended before a full window: one flagged result.
                                r_short <= 1'b1;
                                r_fend  <= 1'b1;
                                r_d     <= '0;
                                r_dend  <= '0;
                                r_seen  <= '0;
                                r_state <= S_EMIT;
                            end else begin
                                r_seen <= n_seen;
                            end
                        end else begin
                            r_short  <= 1'b0;
                            r_fend   <= i_frame_end;
                            r_seen   <= i_frame_end ? '0 : n_seen;
                            r_d      <= (n_seen == sgs_pkg::COUNT_BITS'(win_len))
                                        ? sgs_pkg::ADDR_BITS'(win_len - 1'b1)
                                        : sgs_pkg::ADDR_BITS'(win_half);
                            r_dend   <= i_frame_end ? '0 : sgs_pkg::ADDR_BITS'(win_half);
                            r_half   <= win_half;
                            r_row    <= win_row;
                            r_row_ok <= win_ok;
                            r_k      <= '0;
                            r_state  <= S_TAP;
                        end
                    end
                end
                S_TAP: begin
                    if (r_k == r_half) begin
                        r_drain <= 2'd2;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (r_drain == 2'd0) begin
                        r_state <= S_DIV;
                    end else begin
                        r_drain <= r_drain - 1'b1;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid    <= 1'b1;
                        r_out_smoothed <= r_short ? '0 : div_result;
                        r_out_last     <= r_fend && (r_d == r_dend);
                        r_out_short    <= r_short;
                        if (r_d == r_dend) begin
                            r_given <= r_fend ? '0 : n_given;
                            r_state <= S_IDLE;
                        end else begin
                            r_given <= n_given;
                            r_d     <= r_d - 1'b1;
                            r_k     <= '0;
                            r_state <= S_TAP;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_smoothed      = r_out_smoothed;
    assign o_last_of_frame = r_out_last;
    assign o_too_short     = r_out_short;

`ifndef SYNTHESIS
    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_too_short) |-> o_last_of_frame)
        else $error("too-short result not marked last of frame");

    a_frame_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_frame_end) |=> (r_seen == '0))
        else $error("sample count not cleared at frame end");
`endif

endmodule
